// File: sv/sfs_pkg.sv
// Package for the sprite frame sequencer: sizes, register indexes, operation
// codes and the controller state type.
// No dependencies; every module of the block imports it.
`default_nettype none

package sfs_pkg;

  // Storage and arithmetic sizes.
  localparam int MaxFrames = 16;
  localparam int TimeBits  = 24;
  localparam int DurW      = 16;
  localparam int IdxW      = $clog2(MaxFrames);
  localparam int SumW      = DurW + IdxW;
  localparam int ModCntW   = $clog2(TimeBits);

  // Field widths that the interface fixes.
  localparam int FramesW   = 5;
  localparam int CoordW    = 12;
  localparam int RectXW    = 16;
  localparam int FrameNumW = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 12;
  localparam int InDataW   = 40;
  localparam int OutDataW  = 64;

  localparam logic [TimeBits-1:0] TimeMax = {TimeBits{1'b1}};

  // Operation carried in the slave tuser.
  localparam logic OpTick  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegLoopEnable  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFramesInUse = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOriginX     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOriginY     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegClipWidth   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegClipHeight  = 3'd5;

  typedef enum logic [2:0] {
    StIdle,
    StWalk,
    StAdd,
    StMod,
    StResp
  } sfs_state_e;

endpackage

`default_nettype wire

// File: sv/sfs_mod_unit.sv
// Bit-serial remainder unit: reduces the elapsed time modulo the animation
// length, one dividend bit per cycle. Depends on sfs_pkg.
`default_nettype none

module sfs_mod_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [sfs_pkg::TimeBits-1:0] dividend_i,
  input  wire logic [sfs_pkg::SumW-1:0]   divisor_i,
  output logic                            done_o,
  output logic [sfs_pkg::SumW-1:0]        rem_o
);
  import sfs_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [ModCntW-1:0]  cnt_q;
  logic [TimeBits-1:0] dvd_q;
  logic [SumW-1:0]     dsr_q;
  logic [SumW-1:0]     rem_q;
  logic [SumW:0]       shifted;
  logic [SumW-1:0]     rem_d;

  // The partial remainder stays below the divisor, so one compare and
  // subtract per step suffices.
  always_comb begin
    shifted = {rem_q, dvd_q[TimeBits-1]};
    if (shifted >= {1'b0, dsr_q}) begin
      rem_d = SumW'(shifted - {1'b0, dsr_q});
    end else begin
      rem_d = shifted[SumW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + ModCntW'(1);
        if (cnt_q == ModCntW'(TimeBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TimeBits-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: sv/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer: stream ports, configuration
// registers, duration memory and controller. Depends on sfs_pkg, sfs_mod_unit.
`default_nettype none

// The sequencer keeps one duration per animation frame in a small synchronous
// memory and an elapsed-time accumulator in Q12.12 seconds. An input item with
// tuser high stores one frame duration and restarts the animation at frame
// zero; an item with tuser low advances time by the tick step. Every item
// produces exactly one output item carrying the current frame index and its
// clip rectangle in the sprite sheet. Items are processed one at a time. A
// write goes from acceptance through the response state to the output
// register. A tick that runs walks the memory one entry per cycle, adds the
// step, then, with looping on and a nonzero total, reduces the time in the
// serial remainder unit, and then presents the result. A tick that is
// skipped (no looping and already on the last frame) goes straight to the
// response state. The output register lets the next item be accepted while
// a result waits to be taken. Configuration is written through
// cfg_we_i/cfg_idx_i/cfg_wdata_i and must only change while the block is
// idle.
module sprite_frame_sequencer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Fields from bit 0: tick_time[15:0], frame_slot[19:16],
  // slot_duration[35:20], zero padding[39:36].
  input  wire logic [sfs_pkg::InDataW-1:0]     s_tdata_i,
  // Fields from bit 0: operation.
  input  wire logic                            s_tuser_i,
  input  wire logic                            s_tvalid_i,
  output logic                                 s_tready_o,
  // Fields from bit 0: frame_number[3:0], rect_x[19:4], rect_y[31:20],
  // rect_w[43:32], rect_h[55:44], time_saturated[56], zero padding[63:57].
  output logic [sfs_pkg::OutDataW-1:0]         m_tdata_o,
  output logic                                 m_tvalid_o,
  input  wire logic                            m_tready_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [sfs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [sfs_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import sfs_pkg::*;

  // Configuration registers.
  logic               loop_q;
  logic [FramesW-1:0] frames_q;
  logic [CoordW-1:0]  ox_q, oy_q, cw_q, ch_q;

  // Controller state and datapath registers.
  sfs_state_e          state_q, state_d;
  logic [TimeBits-1:0] elapsed_q, elapsed_d;
  logic [IdxW-1:0]     cur_q, cur_d;
  logic                sat_q, sat_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic                found_q, found_d;
  logic [IdxW:0]       rd_cnt_q, rd_cnt_d;
  logic                rvalid_q, rvalid_d;
  logic [IdxW-1:0]     ridx_q, ridx_d;
  logic [DurW-1:0]     tick_q, tick_d;
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  // Duration memory, one read port and one write port.
  logic [DurW-1:0] dur_mem [MaxFrames];
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [DurW-1:0] mem_wdata;
  logic [IdxW-1:0] mem_raddr;
  logic [DurW-1:0] mem_rdata_q;

  // Remainder unit handshake.
  logic                mod_start;
  logic                mod_done;
  logic [SumW-1:0]     mod_rem;

  // Derived values.
  logic [IdxW:0]       n_act;
  logic [IdxW-1:0]     last_idx;
  logic [SumW-1:0]     sum_new;
  logic [TimeBits:0]   tsum;
  logic [RectXW-1:0]   rect_x;

  // Configuration port; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q   <= 1'b0;
      frames_q <= FramesW'(1);
      ox_q     <= '0;
      oy_q     <= '0;
      cw_q     <= '0;
      ch_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLoopEnable:  loop_q   <= cfg_wdata_i[0];
        RegFramesInUse: frames_q <= cfg_wdata_i[FramesW-1:0];
        RegOriginX:     ox_q     <= cfg_wdata_i;
        RegOriginY:     oy_q     <= cfg_wdata_i;
        RegClipWidth:   cw_q     <= cfg_wdata_i;
        RegClipHeight:  ch_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A frame count of zero acts as one, and counts above the table size are
  // clamped to the table size.
  always_comb begin
    if (frames_q == '0) begin
      n_act = (IdxW + 1)'(1);
    end else if (FramesW'(frames_q) > FramesW'(MaxFrames)) begin
      n_act = (IdxW + 1)'(MaxFrames);
    end else begin
      n_act = (IdxW + 1)'(frames_q);
    end
    last_idx = IdxW'(n_act - (IdxW + 1)'(1));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dur_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= dur_mem[mem_raddr];
  end

  // Write items only touch the memory while idle and read data is only used
  // during the walk, so the two ports never meet on one entry.
  assign mem_waddr = s_tdata_i[19:16];
  assign mem_wdata = s_tdata_i[35:20];
  assign mem_raddr = rd_cnt_q[IdxW-1:0];

  assign sum_new = sum_q + SumW'(mem_rdata_q);
  assign tsum    = {1'b0, elapsed_q} + (TimeBits + 1)'(tick_q);
  assign rect_x  = RectXW'(ox_q) + (RectXW'(cur_q) * RectXW'(cw_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      elapsed_q   <= '0;
      cur_q       <= '0;
      sat_q       <= 1'b0;
      found_q     <= 1'b0;
      rd_cnt_q    <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elapsed_q   <= elapsed_d;
      cur_q       <= cur_d;
      sat_q       <= sat_d;
      found_q     <= found_d;
      rd_cnt_q    <= rd_cnt_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    ridx_q     <= ridx_d;
    tick_q     <= tick_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d     = state_q;
    elapsed_d   = elapsed_q;
    cur_d       = cur_q;
    sat_d       = sat_q;
    sum_d       = sum_q;
    found_d     = found_q;
    rd_cnt_d    = rd_cnt_q;
    rvalid_d    = 1'b0;
    ridx_d      = ridx_q;
    tick_d      = tick_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_tready_i;
    mem_we      = 1'b0;
    mod_start   = 1'b0;
    s_tready_o  = 1'b0;

    unique case (state_q)
      StIdle: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          tick_d = s_tdata_i[15:0];
          sat_d  = 1'b0;
          if (s_tuser_i == OpWrite) begin
            mem_we    = 1'b1;
            elapsed_d = '0;
            cur_d     = '0;
            state_d   = StResp;
          end else if (loop_q || (cur_q < last_idx)) begin
            sum_d    = '0;
            found_d  = 1'b0;
            rd_cnt_d = '0;
            state_d  = StWalk;
          end else begin
            state_d = StResp;
          end
        end
      end

      // Reads are issued one per cycle; the data of each arrives in the next cycle
      // and is added to the running sum.
      StWalk: begin
        if (rd_cnt_q < n_act) begin
          rd_cnt_d = rd_cnt_q + (IdxW + 1)'(1);
          rvalid_d = 1'b1;
          ridx_d   = rd_cnt_q[IdxW-1:0];
        end
        if (rvalid_q) begin
          sum_d = sum_new;
          if (!found_q && (elapsed_q <= TimeBits'(sum_new))) begin
            found_d = 1'b1;
            cur_d   = ridx_q;
          end
          if (ridx_q == last_idx) begin
            rvalid_d = 1'b0;
            state_d  = StAdd;
          end
        end
      end

      StAdd: begin
        if (tsum >= (TimeBits + 1)'(TimeMax)) begin
          elapsed_d = TimeMax;
          sat_d     = 1'b1;
        end else begin
          elapsed_d = tsum[TimeBits-1:0];
        end
        if (loop_q && (sum_q != '0)) begin
          mod_start = 1'b1;
          state_d   = StMod;
        end else begin
          state_d = StResp;
        end
      end

      StMod: begin
        if (mod_done) begin
          elapsed_d = TimeBits'(mod_rem);
          state_d   = StResp;
        end
      end

      StResp: begin
        if (!out_valid_q || m_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = OutDataW'({sat_q, ch_q, cw_q, oy_q, rect_x, cur_q});
          state_d     = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  sfs_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (elapsed_d),
    .divisor_i  (sum_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

  // A write item restarts the animation from frame zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && (s_tuser_i == OpWrite))
      |=> (elapsed_q == '0) && (cur_q == '0))
    else $error("write item did not restart the animation");

  // Read data is only expected while the walk is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == StWalk))
    else $error("memory read data outside the walk");

  // The remainder unit only finishes while the controller waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == StMod))
    else $error("remainder done outside the modulo state");

endmodule

`default_nettype wire
